FILE: design/tri_area_pkg.sv
package tri_area_pkg;

  // Default coordinate width (two's complement integer) and fraction width.
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 8;

  // Width of the area result.
  localparam int AREA_W = 32;

endpackage

FILE: design/tri_area_isqrt.sv
// Pipelined integer square root, one root bit per stage, several lanes in lockstep.
module tri_area_isqrt
  import tri_area_pkg::*;
#(
  parameter int IW    = 42,
  parameter int LANES = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [LANES-1:0][IW-1:0]       in_rad,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [LANES-1:0][IW/2-1:0]     out_root
);

  localparam int OW = IW / 2;
  localparam int RW = OW + 2;
  localparam int TW = OW + 4;

  logic                         v     [OW];
  logic [LANES-1:0][IW-1:0]     x     [OW];
  logic [LANES-1:0][RW-1:0]     rem   [OW];
  logic [LANES-1:0][OW-1:0]     q     [OW];
  logic                         en    [OW+1];

  logic                         src_v   [OW];
  logic [LANES-1:0][IW-1:0]     src_x   [OW];
  logic [LANES-1:0][RW-1:0]     src_rem [OW];
  logic [LANES-1:0][OW-1:0]     src_q   [OW];

  assign en[OW]    = out_ready;
  assign in_ready  = en[0];
  assign out_valid = v[OW-1];
  assign out_root  = q[OW-1];

  for (genvar s = 0; s < OW; s++) begin : g_stage
    logic [LANES-1:0][IW-1:0] nx;
    logic [LANES-1:0][RW-1:0] nrem;
    logic [LANES-1:0][OW-1:0] nq;

    if (s == 0) begin : g_first
      assign src_v[s]   = in_valid;
      assign src_x[s]   = in_rad;
      assign src_rem[s] = '0;
      assign src_q[s]   = '0;
    end else begin : g_rest
      assign src_v[s]   = v[s-1];
      assign src_x[s]   = x[s-1];
      assign src_rem[s] = rem[s-1];
      assign src_q[s]   = q[s-1];
    end

    assign en[s] = !v[s] || en[s+1];

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
      logic [TW-1:0] rcat;
      logic [TW-1:0] trial;
      for (int l = 0; l < LANES; l++) begin
        rcat  = {src_rem[s][l], src_x[s][l][IW-1:IW-2]};
        trial = TW'({src_q[s][l], 2'b01});
        nx[l] = src_x[s][l] << 2;
        if (rcat >= trial) begin
          nrem[l] = RW'(rcat - trial);
          nq[l]   = {src_q[s][l][OW-2:0], 1'b1};
        end else begin
          nrem[l] = rcat[RW-1:0];
          nq[l]   = {src_q[s][l][OW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en[s]) begin
        v[s] <= src_v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        x[s]   <= nx;
        rem[s] <= nrem;
        q[s]   <= nq;
      end
    end
  end

endmodule

FILE: design/triangle_area_from_vertices_top.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------
// input    | in_valid / in_ready  | first_x first_y second_x second_y third_x third_y
// output   | out_valid / out_ready| area_fixed
//
// One triangle is accepted per cycle while the output does not stall, and one
// area comes out per transfer. In order the pipeline holds two stages of
// differences and squares, the side square root (one bit per stage), four stages
// of semiperimeter terms and products, and the area square root (one bit a stage).
// Reset is synchronous and clears every valid bit; payload registers are not reset.
// Each stage moves when it is empty or the stage after it moves, so a stall on the
// output fills bubbles first and never drops or repeats a transfer.
module triangle_area_from_vertices_top
  import tri_area_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] first_x,
  input  logic signed [COORD_BITS-1:0] first_y,
  input  logic signed [COORD_BITS-1:0] second_x,
  input  logic signed [COORD_BITS-1:0] second_y,
  input  logic signed [COORD_BITS-1:0] third_x,
  input  logic signed [COORD_BITS-1:0] third_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [AREA_W-1:0]            area_fixed
);

  // Width plan. A squared distance takes 2*COORD_BITS+1 bits; it is scaled by
  // 2^(2*FRAC_BITS) and padded to an even width so its root has SW bits.
  localparam int C    = COORD_BITS;
  localparam int SQW  = 2 * C + 1;
  localparam int RADW = SQW + 2 * FRAC_BITS;
  localparam int RADE = RADW + (RADW % 2);
  localparam int SW   = RADE / 2;
  // Doubled semiperimeter terms, their pairwise products, the full product.
  localparam int PSW  = SW + 2;
  localparam int MW   = 2 * PSW;
  localparam int PRW  = 2 * MW;
  localparam int WW   = (MW > AREA_W) ? MW : AREA_W;

  // Stage 1: absolute coordinate differences for the three sides.
  // Side 0 is first-second, side 1 is first-third, side 2 is second-third.
  logic                s1_v;
  logic [2:0][C-1:0]   s1_dx, s1_dy;
  logic [2:0][C-1:0]   dx_next, dy_next;
  logic                en1;

  // Stage 2: scaled squared distances.
  logic                s2_v;
  logic [2:0][RADE-1:0] s2_rad;
  logic [2:0][RADE-1:0] rad_next;
  logic                en2;

  // Side square roots.
  logic                sq1_in_ready, sq1_out_valid;
  logic [2:0][SW-1:0]  side;

  // Stage 3: doubled semiperimeter and the three clamped doubled factors.
  logic                s3_v;
  logic [PSW-1:0]      s3_p, s3_q, s3_r, s3_t;
  logic [PSW-1:0]      p_next, q_next, r_next, t_next;
  logic                en3;

  // Stage 4: two products of pairs.
  logic                s4_v;
  logic [MW-1:0]       s4_m1, s4_m2;
  logic                en4;

  // Stage 5: four partial products of the final multiply.
  logic                s5_v;
  logic [MW-1:0]       s5_hh, s5_hl, s5_lh, s5_ll;
  logic                en5;

  // Stage 6: the full product, 16 * s(s-a)(s-b)(s-c) scaled by 2^(4*FRAC_BITS).
  logic                s6_v;
  logic [PRW-1:0]      s6_prod;
  logic                en6;

  logic                sq2_in_ready;
  logic [MW-1:0]       root;
  logic [WW-1:0]       area_wide;

  assign en1      = !s1_v || en2;
  assign en2      = !s2_v || sq1_in_ready;
  assign en3      = !s3_v || en4;
  assign en4      = !s4_v || en5;
  assign en5      = !s5_v || en6;
  assign en6      = !s6_v || sq2_in_ready;
  assign in_ready = en1;

  // Stage 1 logic: subtract in one extra bit, then take the magnitude.
  always_comb begin
    logic signed [C:0] d [6];
    d[0] = {first_x[C-1], first_x} - {second_x[C-1], second_x};
    d[1] = {first_y[C-1], first_y} - {second_y[C-1], second_y};
    d[2] = {first_x[C-1], first_x} - {third_x[C-1], third_x};
    d[3] = {first_y[C-1], first_y} - {third_y[C-1], third_y};
    d[4] = {second_x[C-1], second_x} - {third_x[C-1], third_x};
    d[5] = {second_y[C-1], second_y} - {third_y[C-1], third_y};
    for (int k = 0; k < 3; k++) begin
      dx_next[k] = d[2*k][C]   ? C'(-d[2*k])   : d[2*k][C-1:0];
      dy_next[k] = d[2*k+1][C] ? C'(-d[2*k+1]) : d[2*k+1][C-1:0];
    end
  end

  // Stage 2 logic: sum of squares, shifted up by the doubled fraction width.
  always_comb begin
    logic [2*C-1:0] sqx, sqy;
    logic [SQW-1:0] ssum;
    for (int k = 0; k < 3; k++) begin
      sqx         = s1_dx[k] * s1_dx[k];
      sqy         = s1_dy[k] * s1_dy[k];
      ssum        = SQW'(sqx) + SQW'(sqy);
      rad_next[k] = RADE'(ssum) << (2 * FRAC_BITS);
    end
  end

  // Stage 3 logic: a negative factor left by rounding is clamped to zero.
  always_comb begin
    logic [PSW-1:0] a, b, c;
    a      = PSW'(side[0]);
    b      = PSW'(side[1]);
    c      = PSW'(side[2]);
    p_next = a + b + c;
    q_next = (b + c > a) ? b + c - a : '0;
    r_next = (a + c > b) ? a + c - b : '0;
    t_next = (a + b > c) ? a + b - c : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
    end else begin
      if (en1) begin
        s1_v <= in_valid;
      end
      if (en2) begin
        s2_v <= s1_v;
      end
      if (en3) begin
        s3_v <= sq1_out_valid;
      end
      if (en4) begin
        s4_v <= s3_v;
      end
      if (en5) begin
        s5_v <= s4_v;
      end
      if (en6) begin
        s6_v <= s5_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_dx <= dx_next;
      s1_dy <= dy_next;
    end
    if (en2) begin
      s2_rad <= rad_next;
    end
    if (en3) begin
      s3_p <= p_next;
      s3_q <= q_next;
      s3_r <= r_next;
      s3_t <= t_next;
    end
    if (en4) begin
      s4_m1 <= s3_p * s3_q;
      s4_m2 <= s3_r * s3_t;
    end
    // The wide multiply is split into halves so each multiplier stays narrow.
    if (en5) begin
      s5_hh <= s4_m1[MW-1:PSW] * s4_m2[MW-1:PSW];
      s5_hl <= s4_m1[MW-1:PSW] * s4_m2[PSW-1:0];
      s5_lh <= s4_m1[PSW-1:0]  * s4_m2[MW-1:PSW];
      s5_ll <= s4_m1[PSW-1:0]  * s4_m2[PSW-1:0];
    end
    if (en6) begin
      s6_prod <= (PRW'(s5_hh) << MW) + (PRW'(s5_hl) << PSW)
               + (PRW'(s5_lh) << PSW) + PRW'(s5_ll);
    end
  end

  tri_area_isqrt #(
    .IW    (RADE),
    .LANES (3)
  ) u_side_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_v),
    .in_ready  (sq1_in_ready),
    .in_rad    (s2_rad),
    .out_valid (sq1_out_valid),
    .out_ready (en3),
    .out_root  (side)
  );

  tri_area_isqrt #(
    .IW    (PRW),
    .LANES (1)
  ) u_area_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s6_v),
    .in_ready  (sq2_in_ready),
    .in_rad    (s6_prod),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_root  (root)
  );

  // The root is taken of 16*s(s-a)(s-b)(s-c), so it is four times the area, hence the two
  // extra bits of shift; the result saturates at the top of the 32-bit range.
  assign area_wide  = WW'(root) >> (FRAC_BITS + 2);
  assign area_fixed = (area_wide > WW'({AREA_W{1'b1}})) ? {AREA_W{1'b1}}
                                                        : area_wide[AREA_W-1:0];

endmodule

FILE: design/tri_area_checker.sv
module tri_area_checker
  import tri_area_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [AREA_W-1:0] area_fixed
);

  // A stalled result stays offered.
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(area_fixed))
    else $error("result changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered right after reset");

  // With the output side free the whole pipeline can move, so input is taken.
  a_ready_free : assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled although the output side is free");

endmodule

bind triangle_area_from_vertices_top tri_area_checker u_tri_area_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .area_fixed (area_fixed)
);
